// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of aclk outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Check a property on every rising edge of aclk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ===== src/pbs_pkg.sv =====
package pbs_pkg;

    localparam int AdcBits = 12;

    localparam int SFieldW = AdcBits + 5;
    localparam int SDataW  = ((SFieldW + 7) / 8) * 8;
    localparam int MDataW  = 16;
    localparam int MUserW  = 3;
    localparam int CfgW    = 16;
    localparam int CfgAddrW = 3;

    localparam int MaxMsgs = 4;

    localparam int PctMax        = 100;
    localparam int PctDivisor    = 27;
    localparam int PctClampLevel = PctDivisor * (PctMax + 1);
    localparam int PctShift      = 16;
    localparam int PctRecip      = ((1 << PctShift) + PctDivisor - 1) / PctDivisor;
    localparam int PctInW        = 12;

    localparam logic [9:0] TimerMax = 10'd1023;

    typedef enum logic [1:0] {
        ST_CHARGING = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOAC     = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        K_PRESS   = 2'd0,
        K_SHORT   = 2'd1,
        K_TOFF    = 2'd2,
        K_PERCENT = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_OFF     = 2'd1,
        CMD_BATTERY = 2'd2
    } cmd_t;

    typedef enum logic [CfgAddrW-1:0] {
        CFG_ON_HOLD    = 3'd0,
        CFG_OFF_HOLD   = 3'd1,
        CFG_SHORT      = 3'd2,
        CFG_RELEASE    = 3'd3,
        CFG_FORCED_OFF = 3'd4,
        CFG_REPORT_GAP = 3'd5
    } cfg_addr_t;

    typedef struct packed {
        logic [1:0]         host_command;
        logic [AdcBits-1:0] adc_sample;
        logic               charge_pin;
        logic               ac_present;
        logic               button_level;
    } in_item_t;

    typedef struct packed {
        status_t    status;
        kind_t      kind;
        logic [6:0] percent;
    } msg_t;

    typedef struct packed {
        logic                     power_enable;
        logic                     led_white;
        logic                     led_green;
        msg_t [MaxMsgs-1:0]       msgs;
        logic [2:0]               count;
    } batch_t;

    typedef struct packed {
        logic       power_enable;
        logic       led_white;
        logic       led_green;
        logic       tx_valid;
        msg_t       msg;
        logic       last;
    } beat_t;

endpackage

// ===== src/pbs_core.sv =====
module pbs_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [pbs_pkg::CfgAddrW-1:0]  cfg_addr,
    input  logic [pbs_pkg::CfgW-1:0]      cfg_wdata,
    input  logic                          step_en,
    input  pbs_pkg::in_item_t             item,
    output pbs_pkg::batch_t               batch_next
);

    typedef struct packed {
        logic                        pressed;
        logic [15:0]                 press_cnt;
        logic [7:0]                  rel_cnt;
        logic                        powered;
        logic                        pending;
        logic                        quick;
        logic [15:0]                 off_cnt;
        logic [7:0]                  blink_cnt;
        pbs_pkg::status_t            status;
        pbs_pkg::status_t            last_status;
        logic [pbs_pkg::AdcBits-1:0] fv;
        logic [6:0]                  pct;
        logic [6:0]                  last_pct;
        logic [9:0]                  rpt_timer;
        logic                        power_pin;
        logic                        white;
        logic                        green;
    } state_t;

    localparam logic [2:0] GreenOnPhase  = 3'd0;
    localparam logic [2:0] GreenOffPhase = 3'd4;

    localparam state_t StateReset = '{
        pressed:     1'b0,
        press_cnt:   16'd0,
        rel_cnt:     8'd0,
        powered:     1'b0,
        pending:     1'b0,
        quick:       1'b0,
        off_cnt:     16'd0,
        blink_cnt:   8'd0,
        status:      pbs_pkg::ST_NOAC,
        last_status: pbs_pkg::ST_NOAC,
        fv:          '0,
        pct:         7'd0,
        last_pct:    7'd0,
        rpt_timer:   10'd0,
        power_pin:   1'b0,
        white:       1'b1,
        green:       1'b1
    };

    state_t      state_reg, state_next;
    logic [15:0] on_hold_reg, off_hold_reg, short_reg;
    logic [7:0]  release_reg;
    logic [9:0]  forced_off_reg, report_gap_reg;

    function automatic pbs_pkg::batch_t push_msg(pbs_pkg::batch_t b, pbs_pkg::status_t st,
                                                 pbs_pkg::kind_t k, logic [6:0] p);
        pbs_pkg::batch_t r;
        r = b;
        r.msgs[b.count[1:0]] = '{status: st, kind: k, percent: p};
        r.count = b.count + 3'd1;
        return r;
    endfunction

    function automatic logic blink_dark(logic [7:0] b);
        return b inside {[8'd0:8'd63], [8'd129:8'd191]};
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            on_hold_reg    <= 16'd150;
            off_hold_reg   <= 16'd250;
            short_reg      <= 16'd50;
            release_reg    <= 8'd3;
            forced_off_reg <= 10'd999;
            report_gap_reg <= 10'd50;
        end else if (cfg_we) begin
            case (cfg_addr)
                pbs_pkg::CFG_ON_HOLD:    on_hold_reg    <= cfg_wdata;
                pbs_pkg::CFG_OFF_HOLD:   off_hold_reg   <= cfg_wdata;
                pbs_pkg::CFG_SHORT:      short_reg      <= cfg_wdata;
                pbs_pkg::CFG_RELEASE:    release_reg    <= cfg_wdata[7:0];
                pbs_pkg::CFG_FORCED_OFF: forced_off_reg <= cfg_wdata[9:0];
                pbs_pkg::CFG_REPORT_GAP: report_gap_reg <= cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= StateReset;
        end else if (step_en) begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_t                      s;
        pbs_pkg::batch_t             b;
        logic [pbs_pkg::AdcBits+1:0] fsum;
        logic [31:0]                 fv_ext;
        logic [23:0]                 prod;

        s = state_reg;
        b = '0;

        if (!item.button_level && !s.pressed) begin
            s.white     = 1'b0;
            s.green     = 1'b0;
            s.press_cnt = '0;
            b           = push_msg(b, s.status, pbs_pkg::K_PRESS, 7'd0);
            s.pressed   = 1'b1;
        end else if (!item.button_level) begin
            if (s.press_cnt != 16'hFFFF) begin
                s.press_cnt = s.press_cnt + 16'd1;
                if (!s.powered) begin
                    if (s.press_cnt == on_hold_reg) begin
                        s.power_pin = 1'b1;
                        s.white     = 1'b0;
                        s.green     = 1'b1;
                        s.pending   = 1'b1;
                    end
                end else if (s.press_cnt == off_hold_reg) begin
                    b       = push_msg(b, s.status, pbs_pkg::K_TOFF, 7'd0);
                    s.white = 1'b0;
                    s.green = 1'b0;
                    s.quick = 1'b1;
                    s.off_cnt = '0;
                end
            end
        end else if (s.pressed) begin
            if (s.rel_cnt >= release_reg) begin
                if (s.pending) begin
                    s.powered = 1'b1;
                    s.pending = 1'b0;
                end
                if (s.press_cnt < short_reg) begin
                    b = push_msg(b, s.status, pbs_pkg::K_SHORT, 7'd0);
                end
                s.press_cnt = 16'hFFFF;
                s.rel_cnt   = '0;
                s.pressed   = 1'b0;
            end else begin
                s.rel_cnt = s.rel_cnt + 8'd1;
            end
        end

        if (!s.quick) begin
            if (!s.pressed) begin
                if (item.ac_present) begin
                    if (!item.charge_pin) begin
                        s.status    = pbs_pkg::ST_CHARGING;
                        s.blink_cnt = s.blink_cnt + 8'd1;
                        if (blink_dark(s.blink_cnt)) begin
                            s.white = 1'b0;
                            s.green = s.powered;
                        end else begin
                            s.white = 1'b1;
                            s.green = 1'b0;
                        end
                    end else begin
                        s.status = pbs_pkg::ST_FULL;
                        s.white  = !s.powered;
                        s.green  = s.powered;
                    end
                end else begin
                    s.status = pbs_pkg::ST_NOAC;
                    s.white  = 1'b0;
                    s.green  = s.powered;
                end
            end
            if (s.last_status != s.status) begin
                if (s.powered) begin
                    b = push_msg(b, s.status, pbs_pkg::K_PERCENT, s.pct);
                end
                s.last_status = s.status;
            end
        end else begin
            if (s.off_cnt < {6'd0, forced_off_reg}) begin
                s.off_cnt = s.off_cnt + 16'd1;
                if (s.off_cnt == {6'd0, forced_off_reg}) begin
                    s.quick     = 1'b0;
                    s.power_pin = 1'b0;
                    s.white     = 1'b0;
                    s.green     = 1'b0;
                    s.powered   = 1'b0;
                    s.off_cnt   = 16'hFFFF;
                end
            end
            s.blink_cnt = s.blink_cnt + 8'd1;
            s.white     = 1'b0;
            if (s.blink_cnt[2:0] == GreenOnPhase) begin
                s.green = 1'b1;
            end else if (s.blink_cnt[2:0] == GreenOffPhase) begin
                s.green = 1'b0;
            end
        end

        case (item.host_command)
            pbs_pkg::CMD_OFF: begin
                s.quick     = 1'b0;
                s.power_pin = 1'b0;
                s.white     = 1'b0;
                s.green     = 1'b0;
                s.powered   = 1'b0;
            end
            pbs_pkg::CMD_BATTERY: begin
                b = push_msg(b, s.status, pbs_pkg::K_PERCENT, s.pct);
            end
            default: ;
        endcase

        fsum = ({2'b00, s.fv} << 1) + {2'b00, s.fv} + {2'b00, item.adc_sample}
             + (pbs_pkg::AdcBits + 2)'(2);
        s.fv   = fsum[pbs_pkg::AdcBits+1:2];
        fv_ext = 32'(s.fv);
        prod   = 24'(fv_ext[pbs_pkg::PctInW-1:0]) * 24'(pbs_pkg::PctRecip);
        if (fv_ext >= 32'(pbs_pkg::PctClampLevel)) begin
            s.pct = 7'(pbs_pkg::PctMax);
        end else begin
            s.pct = prod[pbs_pkg::PctShift+6:pbs_pkg::PctShift];
        end

        if (s.rpt_timer != pbs_pkg::TimerMax) begin
            s.rpt_timer = s.rpt_timer + 10'd1;
        end
        if (s.last_pct != s.pct && s.rpt_timer > report_gap_reg) begin
            if (s.powered) begin
                b = push_msg(b, s.status, pbs_pkg::K_PERCENT, s.pct);
            end
            s.rpt_timer = '0;
            s.last_pct  = s.pct;
        end

        b.power_enable = s.power_pin;
        b.led_white    = s.white;
        b.led_green    = s.green;

        state_next = s;
        batch_next = b;
    end

endmodule

// ===== src/pbs_tx.sv =====
module pbs_tx (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            load,
    input  pbs_pkg::batch_t batch_in,
    output logic            batch_ready,
    output logic            beat_valid,
    input  logic            beat_ready,
    output pbs_pkg::beat_t  beat
);

    pbs_pkg::batch_t batch_reg;
    logic            valid_reg;
    logic [1:0]      idx_reg;
    logic [1:0]      last_idx;
    logic            is_last;
    logic            beat_done;

    assign last_idx    = (batch_reg.count == 3'd0) ? 2'd0 : 2'(batch_reg.count - 3'd1);
    assign is_last     = (idx_reg == last_idx);
    assign beat_done   = valid_reg && beat_ready;
    assign batch_ready = !valid_reg || (beat_done && is_last);
    assign beat_valid  = valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (load) begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end else if (beat_done && is_last) begin
            valid_reg <= 1'b0;
        end else if (beat_done) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            batch_reg <= batch_in;
        end
    end

    always_comb begin
        beat.power_enable = batch_reg.power_enable;
        beat.led_white    = batch_reg.led_white;
        beat.led_green    = batch_reg.led_green;
        beat.tx_valid     = (batch_reg.count != 3'd0);
        beat.msg          = beat.tx_valid ? batch_reg.msgs[idx_reg] : '0;
        beat.last         = is_last;
    end

endmodule

// ===== src/power_button_sequencer.sv =====
// Power button sequencer, one input beat per 20 ms tick.
// s_ channel: one beat per tick with the button, AC-present and charger
// pins, a converter sample and the decoded host command.
// m_ channel: one to four beats per tick. Each beat carries the pin levels
// after the tick (same in every beat of a tick); a beat with tx_valid set
// carries a host message, a tick without messages gives one quiet beat.
// m_tlast marks the last beat of a tick.
// cfg port: write cfg_wdata to register cfg_addr while the block is idle.
// Path: an input register holds each taken input beat and feeds the state
// update, whose result is held in a tick buffer; m_tvalid rises once the
// buffer is loaded, and the m_ channel drains it one beat per cycle while
// m_tready is high. A waiting tick enters the buffer in the same cycle that
// the last beat of the previous tick (1 to 4 beats) is taken.
// Reset: the state and configuration registers take their defaults, power
// off, both LEDs on, no beat pending.
// Stall: a stalled m_ beat holds; one further tick waits in the input
// register, then s_tready drops.
module power_button_sequencer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [pbs_pkg::CfgAddrW-1:0]  cfg_addr,
    input  logic [pbs_pkg::CfgW-1:0]      cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // button_level, ac_present, charge_pin, adc_sample, host_command
    input  logic [pbs_pkg::SDataW-1:0]    s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // power_enable, led_white, led_green, tx_status, tx_percent
    output logic [pbs_pkg::MDataW-1:0]    m_tdata,
    // tx_valid, tx_kind
    output logic [pbs_pkg::MUserW-1:0]    m_tuser,
    output logic                          m_tlast
);

    `include "assert_macros.svh"

    logic              in_valid_reg;
    pbs_pkg::in_item_t in_item_reg;
    logic              load;
    logic              batch_ready;
    pbs_pkg::batch_t   batch_next;
    pbs_pkg::beat_t    beat;

    assign load     = in_valid_reg && batch_ready;
    assign s_tready = !in_valid_reg || load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= pbs_pkg::in_item_t'(s_tdata[pbs_pkg::SFieldW-1:0]);
        end
    end

    pbs_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .step_en    (load),
        .item       (in_item_reg),
        .batch_next (batch_next)
    );

    pbs_tx u_tx (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (load),
        .batch_in    (batch_next),
        .batch_ready (batch_ready),
        .beat_valid  (m_tvalid),
        .beat_ready  (m_tready),
        .beat        (beat)
    );

    assign m_tdata = {4'd0, beat.msg.percent, beat.msg.status,
                      beat.led_green, beat.led_white, beat.power_enable};
    assign m_tuser = {beat.msg.kind, beat.tx_valid};
    assign m_tlast = beat.last;

    `ASSERT_CLK(a_quiet_is_last, m_tvalid && !m_tuser[0] |-> m_tlast,
                "quiet beat not marked last")
    `ASSERT_CLK(a_pct_range, m_tvalid |-> m_tdata[11:5] <= 7'd100,
                "battery percentage above 100")
    `ASSERT_CLK(a_pct_kind, m_tvalid && m_tuser[0] && m_tuser[2:1] != pbs_pkg::K_PERCENT
                |-> m_tdata[11:5] == 7'd0, "percentage on non-battery message")
    `ASSERT_CLK(a_in_hold, in_valid_reg && !load |=> in_valid_reg && $stable(in_item_reg),
                "waiting tick lost from input register")

endmodule

// ===== verif/tb_power_button_sequencer.sv =====
module tb_power_button_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_RESERVED = 2'd3;
    localparam int unsigned VOLT_PER_PCT = 27;
    localparam int unsigned PCT_CLAMP = 100;
    localparam int unsigned RX_HOLD_AFTER = 100;
    localparam int unsigned RX_HOLD_CYCLES = 300;
    localparam int unsigned PRINT_CAP = 40;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         cfg_we = 1'b0;
    logic [pbs_pkg::CfgAddrW-1:0] cfg_addr = '0;
    logic [pbs_pkg::CfgW-1:0]     cfg_wdata = '0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [pbs_pkg::SDataW-1:0]   s_tdata = '0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [pbs_pkg::MDataW-1:0]   m_tdata;
    logic [pbs_pkg::MUserW-1:0]   m_tuser;
    logic                         m_tlast;

    power_button_sequencer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // sequencer state as the block should hold it
    logic [15:0]      on_hold_r, off_hold_r, short_r;
    logic [7:0]       release_r;
    logic [9:0]       forced_r, gap_r;
    logic             pressed, powered, pend_power, flash_mode, pwr_pin, white, green;
    logic [15:0]      press_cnt, off_cnt;
    logic [7:0]       rel_cnt, blink_cnt;
    pbs_pkg::status_t status, last_status;
    logic [11:0]      volt;
    logic [6:0]       pct_now, pct_last;
    logic [9:0]       rpt_timer;
    pbs_pkg::msg_t    tick_msgs[$];

    pbs_pkg::in_item_t pending_ticks[$];
    pbs_pkg::beat_t    expected_beats[$];
    int unsigned       err_cnt = 0;
    int unsigned       beats_seen = 0;
    int unsigned       ticks_in = 0;

    function automatic void reset_sequencer();
        on_hold_r = 16'd150;
        off_hold_r = 16'd250;
        short_r = 16'd50;
        release_r = 8'd3;
        forced_r = 10'd999;
        gap_r = 10'd50;
        pressed = 1'b0;
        powered = 1'b0;
        pend_power = 1'b0;
        flash_mode = 1'b0;
        pwr_pin = 1'b0;
        white = 1'b1;
        green = 1'b1;
        press_cnt = '0;
        off_cnt = '0;
        rel_cnt = '0;
        blink_cnt = '0;
        status = pbs_pkg::ST_NOAC;
        last_status = pbs_pkg::ST_NOAC;
        volt = '0;
        pct_now = '0;
        pct_last = '0;
        rpt_timer = '0;
    endfunction

    function automatic void add_msg(pbs_pkg::kind_t k, logic [6:0] p);
        pbs_pkg::msg_t m;
        m.status = status;
        m.kind = k;
        m.percent = p;
        if (tick_msgs.size() < pbs_pkg::MaxMsgs) tick_msgs.push_back(m);
    endfunction

    function automatic void set_leds(logic w, logic g);
        white = w;
        green = g;
    endfunction

    function automatic logic led_dark(logic [7:0] b);
        return b < 8'd64 || (b > 8'd128 && b < 8'd192);
    endfunction

    function automatic void advance_tick(pbs_pkg::in_item_t t);
        int unsigned acc, q;
        pbs_pkg::beat_t b;
        tick_msgs.delete();

        if (!t.button_level && !pressed) begin
            set_leds(1'b0, 1'b0);
            press_cnt = '0;
            add_msg(pbs_pkg::K_PRESS, '0);
            pressed = 1'b1;
        end else if (!t.button_level) begin
            if (press_cnt != 16'hFFFF) begin
                press_cnt++;
                if (!powered) begin
                    if (press_cnt == on_hold_r) begin
                        pwr_pin = 1'b1;
                        set_leds(1'b0, 1'b1);
                        pend_power = 1'b1;
                    end
                end else if (press_cnt == off_hold_r) begin
                    add_msg(pbs_pkg::K_TOFF, '0);
                    set_leds(1'b0, 1'b0);
                    flash_mode = 1'b1;
                    off_cnt = '0;
                end
            end
        end else if (pressed) begin
            if (rel_cnt >= release_r) begin
                if (pend_power) begin
                    powered = 1'b1;
                    pend_power = 1'b0;
                end
                if (press_cnt < short_r) add_msg(pbs_pkg::K_SHORT, '0);
                press_cnt = 16'hFFFF;
                rel_cnt = '0;
                pressed = 1'b0;
            end else begin
                rel_cnt++;
            end
        end

        if (!flash_mode) begin
            if (!pressed) begin
                if (t.ac_present) begin
                    if (!t.charge_pin) begin
                        status = pbs_pkg::ST_CHARGING;
                        blink_cnt++;
                        if (led_dark(blink_cnt)) set_leds(1'b0, powered);
                        else set_leds(1'b1, 1'b0);
                    end else begin
                        status = pbs_pkg::ST_FULL;
                        if (powered) set_leds(1'b0, 1'b1);
                        else set_leds(1'b1, 1'b0);
                    end
                end else begin
                    status = pbs_pkg::ST_NOAC;
                    set_leds(1'b0, powered);
                end
            end
            if (last_status != status) begin
                if (powered) add_msg(pbs_pkg::K_PERCENT, pct_now);
                last_status = status;
            end
        end else begin
            if (off_cnt < {6'd0, forced_r}) begin
                off_cnt++;
                if (off_cnt == {6'd0, forced_r}) begin
                    flash_mode = 1'b0;
                    pwr_pin = 1'b0;
                    set_leds(1'b0, 1'b0);
                    powered = 1'b0;
                    off_cnt = 16'hFFFF;
                end
            end
            blink_cnt++;
            white = 1'b0;
            if (blink_cnt[2:0] == 3'd0) green = 1'b1;
            else if (blink_cnt[2:0] == 3'd4) green = 1'b0;
        end

        case (t.host_command)
            pbs_pkg::CMD_OFF: begin
                flash_mode = 1'b0;
                pwr_pin = 1'b0;
                set_leds(1'b0, 1'b0);
                powered = 1'b0;
            end
            pbs_pkg::CMD_BATTERY: add_msg(pbs_pkg::K_PERCENT, pct_now);
            default: ;
        endcase

        acc = 3 * int'(volt) + int'(t.adc_sample) + 2;
        volt = 12'(acc >> 2);
        q = int'(volt) / VOLT_PER_PCT;
        pct_now = 7'((q > PCT_CLAMP) ? PCT_CLAMP : q);

        if (rpt_timer != 10'h3FF) rpt_timer++;
        if (pct_last != pct_now && rpt_timer > gap_r) begin
            if (powered) add_msg(pbs_pkg::K_PERCENT, pct_now);
            rpt_timer = '0;
            pct_last = pct_now;
        end

        b.power_enable = pwr_pin;
        b.led_white = white;
        b.led_green = green;
        if (tick_msgs.size() == 0) begin
            b.tx_valid = 1'b0;
            b.msg = '0;
            b.last = 1'b1;
            expected_beats.push_back(b);
        end else begin
            foreach (tick_msgs[i]) begin
                b.tx_valid = 1'b1;
                b.msg = tick_msgs[i];
                b.last = (i == tick_msgs.size() - 1);
                expected_beats.push_back(b);
            end
        end
    endfunction

    // sender: bursts of random length with gaps, some of zero length, between them
    int unsigned       burst_left = 0;
    int unsigned       gap_left = 0;
    logic              nxt_valid;
    pbs_pkg::in_item_t nxt_item;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                advance_tick(pbs_pkg::in_item_t'(s_tdata[$bits(pbs_pkg::in_item_t)-1:0]));
                ticks_in <= ticks_in + 1;
            end
            if (!s_tvalid || s_tready) begin
                nxt_valid = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_ticks.size() > 0) begin
                    nxt_valid = 1'b1;
                    nxt_item = pending_ticks.pop_front();
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end
                s_tvalid <= nxt_valid;
                if (nxt_valid) s_tdata <= pbs_pkg::SDataW'(nxt_item);
            end
        end
    end

    // receiver: stall modes that change now and then, plus one long hold-off
    int unsigned rx_cyc = 0;
    int unsigned rx_mode = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    logic        nxt_ready;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            rx_cyc++;
            if (rx_cyc % 48 == 0) rx_mode = $urandom_range(0, 3);
            if (!hold_done && ticks_in >= RX_HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                nxt_ready = 1'b0;
            end else begin
                case (rx_mode)
                    0: nxt_ready = 1'b1;
                    1: nxt_ready = ($urandom_range(0, 2) != 0);
                    2: nxt_ready = (rx_cyc % 8) < 5;
                    default: begin
                        if (stall_left > 0) begin
                            stall_left--;
                            nxt_ready = 1'b0;
                        end else begin
                            nxt_ready = 1'b1;
                            if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 10);
                        end
                    end
                endcase
            end
            m_tready <= nxt_ready;
        end
    end

    task automatic flag_mismatch(string field, int unsigned got, int unsigned want);
        err_cnt++;
        if (err_cnt <= PRINT_CAP)
            $display("[%0t] beat %0d: %s is %0d, want %0d", $time, beats_seen, field, got, want);
    endtask

    pbs_pkg::beat_t want_beat;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            beats_seen++;
            if (expected_beats.size() == 0) begin
                flag_mismatch("beat with nothing expected", 1, 0);
            end else begin
                want_beat = expected_beats.pop_front();
                if (m_tdata[0] !== want_beat.power_enable)
                    flag_mismatch("power_enable", m_tdata[0], want_beat.power_enable);
                if (m_tdata[1] !== want_beat.led_white)
                    flag_mismatch("led_white", m_tdata[1], want_beat.led_white);
                if (m_tdata[2] !== want_beat.led_green)
                    flag_mismatch("led_green", m_tdata[2], want_beat.led_green);
                if (m_tdata[4:3] !== want_beat.msg.status)
                    flag_mismatch("tx_status", m_tdata[4:3], want_beat.msg.status);
                if (m_tdata[11:5] !== want_beat.msg.percent)
                    flag_mismatch("tx_percent", m_tdata[11:5], want_beat.msg.percent);
                if (m_tdata[15:12] !== 4'd0)
                    flag_mismatch("tdata pad", m_tdata[15:12], 0);
                if (m_tuser[0] !== want_beat.tx_valid)
                    flag_mismatch("tx_valid", m_tuser[0], want_beat.tx_valid);
                if (m_tuser[2:1] !== want_beat.msg.kind)
                    flag_mismatch("tx_kind", m_tuser[2:1], want_beat.msg.kind);
                if (m_tlast !== want_beat.last)
                    flag_mismatch("last", m_tlast, want_beat.last);
            end
        end
    end

    // slowly varying pin and converter levels for random ticks
    logic        rnd_ac = 1'b1;
    logic        rnd_chg = 1'b0;
    logic [11:0] rnd_adc = 12'd2048;

    function automatic void push_tick(logic btn, logic ac, logic chg, logic [11:0] adc,
                                      logic [1:0] cmd);
        pbs_pkg::in_item_t t;
        t.button_level = btn;
        t.ac_present = ac;
        t.charge_pin = chg;
        t.adc_sample = adc;
        t.host_command = cmd;
        pending_ticks.push_back(t);
    endfunction

    function automatic void push_run(int btn, int unsigned count);
        int unsigned r, step;
        logic [1:0] cmd;
        for (int unsigned i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0) rnd_ac = ~rnd_ac;
            if ($urandom_range(0, 9) == 0) rnd_chg = ~rnd_chg;
            r = $urandom_range(0, 15);
            if (r < 3) begin
                rnd_adc = 12'($urandom_range(0, 4095));
            end else if (r == 3) begin
                rnd_adc = ($urandom_range(0, 1) != 0) ? 12'hFFF : 12'h000;
            end else begin
                step = $urandom_range(0, 600);
                if (step >= 300) rnd_adc = (int'(rnd_adc) + step - 300 > 4095) ? 12'hFFF
                                                   : 12'(int'(rnd_adc) + step - 300);
                else rnd_adc = (int'(rnd_adc) < 300 - step) ? 12'h000
                                                   : 12'(int'(rnd_adc) - (300 - step));
            end
            r = $urandom_range(0, 99);
            if (r < 3) cmd = pbs_pkg::CMD_OFF;
            else if (r < 12) cmd = pbs_pkg::CMD_BATTERY;
            else if (r < 15) cmd = CMD_RESERVED;
            else cmd = pbs_pkg::CMD_NONE;
            push_tick((btn < 0) ? 1'($urandom_range(0, 1)) : 1'(btn), rnd_ac, rnd_chg,
                      rnd_adc, cmd);
        end
    endfunction

    // mostly press and release sequences aimed at the hold and short-press thresholds
    function automatic void push_episodes(int unsigned n);
        int unsigned added, len, rel, sel;
        added = 0;
        while (added < n) begin
            sel = $urandom_range(0, 9);
            rel = int'(release_r) + 1 + $urandom_range(0, 3);
            if (rel > 40) rel = 40;
            if (sel <= 3) begin
                len = ($urandom_range(0, 1) != 0) ? int'(on_hold_r) : int'(off_hold_r);
                len = len + $urandom_range(0, 3);
                len = (len > 1) ? len - 1 : 1;
                if (len > 40) len = 40;
                push_run(0, len);
                push_run(1, rel);
                added += len + rel;
            end else if (sel <= 5) begin
                len = $urandom_range(1, int'(short_r) + 1);
                if (len > 20) len = 20;
                push_run(0, len);
                push_run(1, rel);
                added += len + rel;
            end else if (sel <= 7) begin
                len = $urandom_range(1, 10);
                push_run(1, len);
                added += len;
            end else if (sel == 8) begin
                len = $urandom_range(1, 6);
                push_run(-1, len);
                added += len;
            end else begin
                len = $urandom_range(1, int'(forced_r) + 4);
                if (len > 40) len = 40;
                push_run(1, len);
                added += len;
            end
        end
    endfunction

    task automatic drain();
        do @(negedge aclk);
        while (pending_ticks.size() != 0 || s_tvalid || expected_beats.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(pbs_pkg::cfg_addr_t a, logic [15:0] v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= a;
        cfg_wdata <= v;
        case (a)
            pbs_pkg::CFG_ON_HOLD:    on_hold_r = v;
            pbs_pkg::CFG_OFF_HOLD:   off_hold_r = v;
            pbs_pkg::CFG_SHORT:      short_r = v;
            pbs_pkg::CFG_RELEASE:    release_r = v[7:0];
            pbs_pkg::CFG_FORCED_OFF: forced_r = v[9:0];
            pbs_pkg::CFG_REPORT_GAP: gap_r = v[9:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_config(logic [15:0] on_h, logic [15:0] off_h, logic [15:0] sh,
                                logic [15:0] rel, logic [15:0] forced, logic [15:0] gap);
        write_reg(pbs_pkg::CFG_ON_HOLD, on_h);
        write_reg(pbs_pkg::CFG_OFF_HOLD, off_h);
        write_reg(pbs_pkg::CFG_SHORT, sh);
        write_reg(pbs_pkg::CFG_RELEASE, rel);
        write_reg(pbs_pkg::CFG_FORCED_OFF, forced);
        write_reg(pbs_pkg::CFG_REPORT_GAP, gap);
    endtask

    initial begin
        reset_sequencer();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: quiet tick, ignored command, request, tap with short release
        push_tick(1'b1, 1'b0, 1'b0, 12'h000, pbs_pkg::CMD_NONE);
        push_tick(1'b1, 1'b0, 1'b1, 12'hFFF, CMD_RESERVED);
        push_tick(1'b1, 1'b1, 1'b1, 12'hFFF, pbs_pkg::CMD_BATTERY);
        push_tick(1'b0, 1'b1, 1'b0, 12'hFFF, pbs_pkg::CMD_NONE);
        for (int i = 0; i < 4; i++) push_tick(1'b1, 1'b1, 1'b0, 12'hFFF, pbs_pkg::CMD_NONE);
        drain();

        // power on, reports, hold to turn-off request, forced cut, host turn-off
        apply_config(16'd2, 16'd3, 16'd2, 16'd0, 16'd4, 16'd0);
        push_tick(1'b0, 1'b1, 1'b0, 12'd2000, pbs_pkg::CMD_NONE);
        push_tick(1'b0, 1'b1, 1'b0, 12'd2000, pbs_pkg::CMD_NONE);
        push_tick(1'b0, 1'b1, 1'b0, 12'd2000, pbs_pkg::CMD_NONE);
        push_tick(1'b1, 1'b1, 1'b0, 12'd2000, pbs_pkg::CMD_NONE);
        push_tick(1'b1, 1'b1, 1'b1, 12'hFFF, pbs_pkg::CMD_BATTERY);
        push_tick(1'b1, 1'b0, 1'b1, 12'hFFF, pbs_pkg::CMD_NONE);
        push_tick(1'b1, 1'b1, 1'b0, 12'hFFF, CMD_RESERVED);
        for (int i = 0; i < 4; i++) push_tick(1'b0, 1'b1, 1'b0, 12'hFFF, pbs_pkg::CMD_NONE);
        for (int i = 0; i < 4; i++) push_tick(1'b1, 1'b1, 1'b0, 12'd0, pbs_pkg::CMD_NONE);
        push_tick(1'b1, 1'b0, 1'b0, 12'd0, pbs_pkg::CMD_OFF);
        drain();

        apply_config(16'd3, 16'd4, 16'd3, 16'd1, 16'd0, 16'd2);
        push_episodes(100);
        drain();

        apply_config(16'd1, 16'd1, 16'd1, 16'd0, 16'd1, 16'd0);
        push_episodes(80);
        drain();

        apply_config(16'd65534, 16'd65534, 16'd65535, 16'd255, 16'd999, 16'd1023);
        push_episodes(40);
        drain();

        for (int p = 0; p < 3; p++) begin
            apply_config(16'($urandom_range(1, 8)), 16'($urandom_range(1, 10)),
                         16'($urandom_range(1, 12)), 16'($urandom_range(0, 4)),
                         16'($urandom_range(0, 30)), 16'($urandom_range(0, 20)));
            push_episodes(70);
            drain();
        end

        repeat (20) @(posedge aclk);
        if (err_cnt == 0 && expected_beats.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== power_button_sequencer.f =====
+incdir+src
src/pbs_pkg.sv
src/pbs_core.sv
src/pbs_tx.sv
src/power_button_sequencer.sv
verif/tb_power_button_sequencer.sv
